FILE: design/aesctr_pkg.sv
`default_nettype none
package aesctr_pkg;

	localparam int BLOCK_BYTES = 16;
	localparam int HALF_BYTES = 8;
	localparam int ROUNDS = 10;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [1:0] REG_KEY_HIGH = 2'd0;
	localparam logic [1:0] REG_KEY_LOW = 2'd1;
	localparam logic [1:0] REG_IV_HIGH = 2'd2;
	localparam logic [1:0] REG_IV_LOW = 2'd3;

	typedef struct packed {
		logic [127:0] ctr;
		logic [127:0] data;
		logic [4:0] count;
	} item_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] RCON [ROUNDS] = '{
		8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
	};

	function automatic logic [63:0] byte_swap(input logic [63:0] v);
		logic [63:0] r;
		for (int i = 0; i < HALF_BYTES; i++) begin
			r[8*i +: 8] = v[8*(HALF_BYTES-1-i) +: 8];
		end
		return r;
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc);
		logic [31:0] t;
		logic [31:0] n0;
		logic [31:0] n1;
		logic [31:0] n2;
		logic [31:0] n3;
		t = {SBOX[k[23:16]] ^ rc, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
		n0 = k[127:96] ^ t;
		n1 = k[95:64] ^ n0;
		n2 = k[63:32] ^ n1;
		n3 = k[31:0] ^ n2;
		return {n0, n1, n2, n3};
	endfunction

	function automatic logic [127:0] aes_round(input logic [127:0] st, input logic [127:0] rk,
			input logic last);
		logic [7:0] s [BLOCK_BYTES];
		logic [7:0] t [BLOCK_BYTES];
		logic [7:0] m [BLOCK_BYTES];
		logic [7:0] all;
		logic [127:0] r;
		for (int i = 0; i < BLOCK_BYTES; i++) begin
			s[i] = st[127-8*i -: 8];
		end
		for (int c = 0; c < 4; c++) begin
			for (int i = 0; i < 4; i++) begin
				t[i+4*c] = SBOX[s[i + 4*((c+i) & 3)]];
			end
		end
		for (int c = 0; c < 4; c++) begin
			all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
			m[4*c]   = t[4*c]   ^ all ^ xtime(t[4*c]   ^ t[4*c+1]);
			m[4*c+1] = t[4*c+1] ^ all ^ xtime(t[4*c+1] ^ t[4*c+2]);
			m[4*c+2] = t[4*c+2] ^ all ^ xtime(t[4*c+2] ^ t[4*c+3]);
			m[4*c+3] = t[4*c+3] ^ all ^ xtime(t[4*c+3] ^ t[4*c]);
		end
		for (int i = 0; i < BLOCK_BYTES; i++) begin
			r[127-8*i -: 8] = (last ? t[i] : m[i]) ^ rk[127-8*i -: 8];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: design/aesctr_queue.sv
`default_nettype none
module aesctr_queue #(
	parameter int DEPTH = aesctr_pkg::QUEUE_DEPTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  aesctr_pkg::item_t       push_item,
	output logic                    full,
	input  wire logic               pop,
	output logic                    not_empty,
	output aesctr_pkg::item_t       head
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	aesctr_pkg::item_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] fill_q;
	logic do_push;
	logic do_pop;

	assign full = (fill_q == CW'(DEPTH));
	assign not_empty = (fill_q != '0);
	assign do_push = push && !full;
	assign do_pop = pop && not_empty;
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

FILE: design/aesctr_front.sv
`default_nettype none
module aesctr_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               accept,
	input  wire logic [63:0]        data_high,
	input  wire logic [63:0]        data_low,
	input  wire logic [4:0]         byte_count,
	input  wire logic               message_start,
	input  wire logic [63:0]        iv_high,
	input  wire logic [63:0]        iv_low,
	output aesctr_pkg::item_t       item
);
	logic [63:0] count_q;
	logic [63:0] cur;

	// iv_low bytes read little-endian
	assign cur = message_start ? aesctr_pkg::byte_swap(iv_low) : count_q;

	always_comb begin
		item.ctr = {iv_high, aesctr_pkg::byte_swap(cur)};
		item.data = {data_high, data_low};
		item.count = byte_count;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= cur + 64'(byte_count >= 5'(aesctr_pkg::BLOCK_BYTES));
		end
	end
endmodule
`default_nettype wire

FILE: design/aesctr_back.sv
`default_nettype none
module aesctr_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [127:0]       key,
	input  wire logic               head_valid,
	input  aesctr_pkg::item_t       head,
	output logic                    pop,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output logic [63:0]             result_high,
	output logic [63:0]             result_low,
	output logic [4:0]              result_count
);
	localparam int NR = aesctr_pkg::ROUNDS;

	logic               vld_s   [NR+1];
	logic [127:0]       state_s [NR+1];
	logic [127:0]       rkey_s  [NR+1];
	logic [127:0]       data_s  [NR+1];
	logic [4:0]         count_s [NR+1];
	logic               out_valid_q;
	logic [127:0]       out_q;
	logic [4:0]         out_count_q;
	logic               en;
	logic [4:0]         keep_n;
	logic [127:0]       masked;

	assign en = !out_valid_q || !result_stall;
	assign pop = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= NR; i++) begin
				vld_s[i] <= 1'b0;
			end
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_s[0] <= head_valid;
			for (int i = 1; i <= NR; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
			out_valid_q <= vld_s[NR];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			state_s[0] <= head.ctr ^ key;
			rkey_s[0] <= key;
			data_s[0] <= head.data;
			count_s[0] <= head.count;
		end
	end

	for (genvar r = 1; r <= NR; r++) begin : g_round
		logic [127:0] nk;
		assign nk = aesctr_pkg::key_step(rkey_s[r-1], aesctr_pkg::RCON[r-1]);
		always_ff @(posedge clk) begin
			if (en) begin
				rkey_s[r] <= nk;
				state_s[r] <= aesctr_pkg::aes_round(state_s[r-1], nk, r == NR);
				data_s[r] <= data_s[r-1];
				count_s[r] <= count_s[r-1];
			end
		end
	end

	assign keep_n = (count_s[NR] > 5'(aesctr_pkg::BLOCK_BYTES)) ?
		5'(aesctr_pkg::BLOCK_BYTES) : count_s[NR];

	always_comb begin
		for (int i = 0; i < aesctr_pkg::BLOCK_BYTES; i++) begin
			masked[127-8*i -: 8] = (5'(i) < keep_n) ?
				(data_s[NR][127-8*i -: 8] ^ state_s[NR][127-8*i -: 8]) : 8'h00;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= masked;
			out_count_q <= count_s[NR];
		end
	end

	assign result_valid = out_valid_q;
	assign result_high = out_q[127:64];
	assign result_low = out_q[63:0];
	assign result_count = out_count_q;
endmodule
`default_nettype wire

FILE: design/aes128_ctr_keystream_xor.sv
// AES-128 counter mode keystream XOR, one 16-byte block per beat.
// input channel: valid/stall with data_high, data_low, byte_count, message_start.
// message_start reloads the 64-bit count from iv_low (read little-endian);
// the count steps after every full block and wraps without carry.
// output channel: result_valid/result_stall with result_high, result_low,
// result_count; bytes past byte_count read as zero.
// config: cfg_write, cfg_index (0 key_high, 1 key_low, 2 iv_high, 3 iv_low),
// cfg_data; write only while no block is in flight.
// a result passes through the queue (written at the input beat), the initial key
// add, ten unrolled rounds and the output register.
// throughput: one beat per cycle while result_stall is low, set by the fully pipelined
// round stages with the round keys expanded alongside the data.
// a 4-entry queue separates input from the round pipeline; stall rises
// when it is full. result_stall freezes the round pipeline and output register while result_valid is high.
// reset clears config, the count, the queue and all valid flags.
`default_nettype none
module aes128_ctr_keystream_xor #(
	parameter int QUEUE_DEPTH = aesctr_pkg::QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        valid,
	output logic             stall,
	input  wire logic [63:0] data_high,
	input  wire logic [63:0] data_low,
	input  wire logic [4:0]  byte_count,
	input  wire logic        message_start,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [63:0]      result_high,
	output logic [63:0]      result_low,
	output logic [4:0]       result_count,
	input  wire logic        cfg_write,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);
	logic [63:0] key_high_q;
	logic [63:0] key_low_q;
	logic [63:0] iv_high_q;
	logic [63:0] iv_low_q;
	logic accept;
	logic full;
	logic pop;
	logic head_valid;
	aesctr_pkg::item_t item;
	aesctr_pkg::item_t head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q <= '0;
			iv_high_q <= '0;
			iv_low_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				aesctr_pkg::REG_KEY_HIGH: key_high_q <= cfg_data;
				aesctr_pkg::REG_KEY_LOW: key_low_q <= cfg_data;
				aesctr_pkg::REG_IV_HIGH: iv_high_q <= cfg_data;
				aesctr_pkg::REG_IV_LOW: iv_low_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign stall = full;
	assign accept = valid && !full;

	aesctr_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.data_high(data_high),
		.data_low(data_low),
		.byte_count(byte_count),
		.message_start(message_start),
		.iv_high(iv_high_q),
		.iv_low(iv_low_q),
		.item(item)
	);

	aesctr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(accept),
		.push_item(item),
		.full(full),
		.pop(pop),
		.not_empty(head_valid),
		.head(head)
	);

	aesctr_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.key({key_high_q, key_low_q}),
		.head_valid(head_valid),
		.head(head),
		.pop(pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_high(result_high),
		.result_low(result_low),
		.result_count(result_count)
	);
endmodule
`default_nettype wire

FILE: design/aesctr_check.sv
`default_nettype none
module aesctr_check (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        result_valid,
	input wire logic        result_stall,
	input wire logic [63:0] result_high,
	input wire logic [63:0] result_low,
	input wire logic [4:0]  result_count
);
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result beat dropped under stall");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(result_high) && $stable(result_low)
			&& $stable(result_count))
		else $error("stalled result changed");

	a_low_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_count <= 5'd8 |-> result_low == 64'd0)
		else $error("bytes past count not zero");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_count == 5'd0 |-> result_high == 64'd0)
		else $error("empty block not zero");
endmodule

bind aes128_ctr_keystream_xor aesctr_check u_check (
	.clk(clk),
	.arst_n(arst_n),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.result_high(result_high),
	.result_low(result_low),
	.result_count(result_count)
);
`default_nettype wire
